/* hw/rtl/bsff_pkg.sv */
// Package for the bit-set store with find-first-set.
// Holds sizes, operation codes, result and RAM request types and the bit search.
// No dependencies.
`default_nettype none
package bsff_pkg;

   localparam int MAX_BITS  = 1024;
   localparam int WORD_BITS = 32;
   localparam int DEPTH     = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int IDX_W     = 10;
   localparam int CNT_W     = ADDR_W + 1;
   localparam int SIZE_W    = 11;
   localparam int FUNC_W    = 3;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);
   localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_BITS);

   // operation codes carried on req_tuser
   localparam logic [FUNC_W-1:0] FN_SET        = 3'd0;
   localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd1;
   localparam logic [FUNC_W-1:0] FN_READ       = 3'd2;
   localparam logic [FUNC_W-1:0] FN_FIND       = 3'd3;
   localparam logic [FUNC_W-1:0] FN_SET_ALL    = 3'd4;
   localparam logic [FUNC_W-1:0] FN_CLEAR_ALL  = 3'd5;
   localparam logic [FUNC_W-1:0] FN_TEST_EMPTY = 3'd6;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_W       = IDX_W + 4;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_W;

   // packed lowest field last: bit_value lands in bit 0
   typedef struct packed {
      logic             error;
      logic             is_empty;
      logic [IDX_W-1:0] first_index;
      logic             found;
      logic             bit_value;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type result;
   } fin_type;

   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_W-1:0]    wr_addr;
      logic [WORD_BITS-1:0] wr_data;
      logic                 rd_en;
      logic [ADDR_W-1:0]    rd_addr;
   } ram_req_type;

   // position of the lowest set bit; 0 for an empty word
   function automatic logic [BIT_W-1:0] first_set(input logic [WORD_BITS-1:0] w);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (w[i]) pos = BIT_W'(i);
      end
      return pos;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/bsff_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module bsff_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/bsff_engine.sv */
// Operation sequencer: read-modify-write, word scan and fill over the word RAM.
// Keeps per-word valid bits so unwritten words read as zero. Uses bsff_pkg.
`default_nettype none
module bsff_engine (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [bsff_pkg::FUNC_W-1:0]        req_func,
   input  wire logic [bsff_pkg::IDX_W-1:0]         req_idx,
   input  wire logic [bsff_pkg::SIZE_W-1:0]        eff_size,
   input  wire logic [bsff_pkg::CNT_W-1:0]         words_used,
   input  wire logic                               out_free,
   output bsff_pkg::ram_req_type                   ram_req,
   input  wire logic [bsff_pkg::WORD_BITS-1:0]     ram_rdata,
   output bsff_pkg::fin_type                       fin
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_RMW  = 5'b00010,
      ST_SCAN = 5'b00100,
      ST_FILL = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type                       state_ff, state_in;
   logic [bsff_pkg::FUNC_W-1:0]     func_ff, func_in;
   logic [bsff_pkg::BIT_W-1:0]      bit_ff, bit_in;
   logic [bsff_pkg::ADDR_W-1:0]     paddr_ff, paddr_in;
   logic [bsff_pkg::CNT_W-1:0]      ptr_ff, ptr_in;
   logic                            pend_ff, pend_in;
   logic [bsff_pkg::DEPTH-1:0]      valid_ff, valid_in;
   bsff_pkg::result_type            res_ff, res_in;

   logic [bsff_pkg::WORD_BITS-1:0]  word_rd;
   logic [bsff_pkg::WORD_BITS-1:0]  mask;
   logic                            hit;
   logic                            fin_now;
   bsff_pkg::result_type            fin_r;

   // a word never written since reset reads as zero
   assign word_rd = valid_ff[paddr_ff] ? ram_rdata : '0;
   assign mask    = bsff_pkg::WORD_BITS'(1) << bit_ff;
   assign hit     = pend_ff && (word_rd != '0);

   always_comb begin
      state_in  = state_ff;
      func_in   = func_ff;
      bit_in    = bit_ff;
      paddr_in  = paddr_ff;
      ptr_in    = ptr_ff;
      pend_in   = pend_ff;
      res_in    = res_ff;
      req_ready = 1'b0;
      ram_req   = '0;
      fin_now   = 1'b0;
      fin_r     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in  = req_func;
               bit_in   = req_idx[bsff_pkg::BIT_W-1:0];
               paddr_in = req_idx[bsff_pkg::IDX_W-1:bsff_pkg::BIT_W];
               ptr_in   = '0;
               pend_in  = 1'b0;
               unique case (req_func)
                  bsff_pkg::FN_SET, bsff_pkg::FN_CLEAR, bsff_pkg::FN_READ: begin
                     if ({1'b0, req_idx} >= eff_size) begin
                        fin_now     = 1'b1;
                        fin_r.error = 1'b1;
                     end else begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = req_idx[bsff_pkg::IDX_W-1:bsff_pkg::BIT_W];
                        state_in        = ST_RMW;
                     end
                  end
                  bsff_pkg::FN_FIND, bsff_pkg::FN_TEST_EMPTY: state_in = ST_SCAN;
                  bsff_pkg::FN_SET_ALL, bsff_pkg::FN_CLEAR_ALL: state_in = ST_FILL;
                  default: fin_now = 1'b1;
               endcase
            end
         end
         ST_RMW: begin
            fin_now = 1'b1;
            priority if (func_ff == bsff_pkg::FN_SET) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = paddr_ff;
               ram_req.wr_data = word_rd | mask;
            end else if (func_ff == bsff_pkg::FN_CLEAR) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = paddr_ff;
               ram_req.wr_data = word_rd & ~mask;
            end else begin
               fin_r.bit_value = |(word_rd & mask);
            end
         end
         ST_SCAN: begin
            // check the word read last cycle, issue the next read meanwhile
            if (hit || ptr_ff == words_used) begin
               fin_now = 1'b1;
               if (func_ff == bsff_pkg::FN_FIND) begin
                  fin_r.found       = hit;
                  fin_r.first_index = hit ? {paddr_ff, bsff_pkg::first_set(word_rd)} : '0;
               end else begin
                  fin_r.is_empty = !hit;
               end
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = ptr_ff[bsff_pkg::ADDR_W-1:0];
               paddr_in        = ptr_ff[bsff_pkg::ADDR_W-1:0];
               pend_in         = 1'b1;
               ptr_in          = ptr_ff + 1'b1;
            end
         end
         ST_FILL: begin
            if (ptr_ff == words_used) begin
               fin_now = 1'b1;
            end else begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = ptr_ff[bsff_pkg::ADDR_W-1:0];
               ram_req.wr_data = (func_ff == bsff_pkg::FN_SET_ALL) ? '1 : '0;
               ptr_in          = ptr_ff + 1'b1;
            end
         end
         ST_DONE: begin
            fin_now = 1'b1;
            fin_r   = res_ff;
         end
         default: state_in = ST_IDLE;
      endcase

      // hand the result over, or hold it until the output register frees up
      if (fin_now) begin
         if (out_free) begin
            state_in = ST_IDLE;
         end else begin
            res_in   = fin_r;
            state_in = ST_DONE;
         end
      end

      valid_in = valid_ff;
      if (ram_req.wr_en) valid_in[ram_req.wr_addr] = 1'b1;
   end

   assign fin.valid  = fin_now;
   assign fin.result = fin_r;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         ptr_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         ptr_ff   <= ptr_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      bit_ff   <= bit_in;
      paddr_ff <= paddr_in;
      res_ff   <= res_in;
   end

endmodule
`default_nettype wire

/* hw/rtl/bitmap_store_with_find_first_unit.sv */
// Top level of the bit-set store with find-first-set.
// Depends on bsff_pkg, bsff_ram and bsff_engine.
//
// A set of up to 1024 bits, kept as 32 words of 32 bits in one synchronous RAM and
// cleared at reset (per-word valid bits make it read as zero at once, so there is no
// clearing pass). Each request beat carries an operation on req_tuser and a bit index
// on req_tdata; every request gives exactly one response beat. Set, clear and read
// issue the RAM read on acceptance, then write the word back or, for read, return the
// bit; an index at or above the configured size, and the unused operation code, finish
// on acceptance and change nothing. Find-first and test-empty read the words in use
// one per cycle, stopping at the first non-zero word; set-all and clear-all write one
// word per cycle. The words in use are the csr size, capped at 1024 bits, rounded up
// to whole 32-bit words. The sequencer takes one request at a time over the single RAM
// read port. A finished response waits in an output register, so the next request is
// taken while the previous response is still stalled. Write the size only while idle.
`default_nettype none
module bitmap_store_with_find_first_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request: tuser = func[2:0]; tdata = bit_index[9:0], zero pad [15:10]
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [bsff_pkg::FUNC_W-1:0]           req_tuser,
   input  wire logic [bsff_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // response: tdata = bit_value[0], found[1], first_index[11:2], is_empty[12],
   // error[13], zero pad [15:14]
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic      [bsff_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // size_in_bits register
   input  wire logic                                  csr_wr_en,
   input  wire logic [bsff_pkg::SIZE_W-1:0]           csr_wr_data
);

   logic [bsff_pkg::SIZE_W-1:0]    size_ff, size_in;
   logic [bsff_pkg::SIZE_W-1:0]    eff_size;
   logic [bsff_pkg::SIZE_W-1:0]    size_round;
   logic [bsff_pkg::CNT_W-1:0]     words_used;
   logic                           rsp_valid_ff, rsp_valid_in;
   bsff_pkg::result_type           rsp_data_ff, rsp_data_in;
   logic                           out_free;
   bsff_pkg::ram_req_type          ram_req;
   logic [bsff_pkg::WORD_BITS-1:0] ram_rdata;
   bsff_pkg::fin_type              fin;

   // saturate the size, then round up to whole words
   assign eff_size   = (size_ff > bsff_pkg::SIZE_MAX) ? bsff_pkg::SIZE_MAX : size_ff;
   assign size_round = eff_size + bsff_pkg::SIZE_W'(bsff_pkg::WORD_BITS - 1);
   assign words_used = bsff_pkg::CNT_W'(size_round >> bsff_pkg::BIT_W);

   assign size_in = csr_wr_en ? csr_wr_data : size_ff;

   always_ff @(posedge clock) begin
      if (reset) size_ff <= bsff_pkg::SIZE_RESET;
      else       size_ff <= size_in;
   end

   bsff_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_func   (req_tuser),
      .req_idx    (req_tdata[bsff_pkg::IDX_W-1:0]),
      .eff_size   (eff_size),
      .words_used (words_used),
      .out_free   (out_free),
      .ram_req    (ram_req),
      .ram_rdata  (ram_rdata),
      .fin        (fin)
   );

   bsff_ram #(
      .WIDTH (bsff_pkg::WORD_BITS),
      .DEPTH (bsff_pkg::DEPTH)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rdata)
   );

   // output register: load a finished beat when empty or draining, drop on take
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fin.valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = fin.result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{bsff_pkg::RSP_PAD_W{1'b0}}, rsp_data_ff};

endmodule
`default_nettype wire

/* hw/rtl/bsff_checker.sv */
// Port-level checks for the bit-set store, bound to the top level.
// Depends on bsff_pkg and bitmap_store_with_find_first_unit.
`default_nettype none
module bsff_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic [bsff_pkg::FUNC_W-1:0]       req_tuser,
   input wire logic [bsff_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [bsff_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input wire logic                              csr_wr_en,
   input wire logic [bsff_pkg::SIZE_W-1:0]       csr_wr_data
);

   // no response beat right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // at most one of bit_value, found, is_empty, error in a beat
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $countones({rsp_tdata[0], rsp_tdata[1], rsp_tdata[12],
                                 rsp_tdata[13]}) <= 1)
      else $error("response mixes result kinds");

   // a response beat carries no unknown bits
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !$isunknown(rsp_tdata))
      else $error("response data unknown");

endmodule

bind bitmap_store_with_find_first_unit bsff_checker u_bsff_checker (.*);
`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the bit-set store with find-first-set (bitmap_store_with_find_first_unit).
// Uses bsff_pkg for the operation codes and the response layout; needs nothing else but the RTL.
// A scoreboard class predicts every response; directed and then random beats are sent under varied idling.
`timescale 1ns / 1ps

module testbench;
   import bsff_pkg::*;

   // func code 7 has no operation behind it; it must leave the store alone and answer all zeros
   localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
   localparam int ITEMS_PER_PHASE = 130;
   localparam int NUM_PHASES      = 10;
   // longest legal quiet stretch is one full-store walk plus receiver stalls
   localparam int QUIET_LIMIT     = 3000;
   localparam int TAIL_CYCLES     = 40;

   // -----------------------------------------------------------------------------------------
   // Scoreboard: keeps its own copy of the word store and the size register, predicts one
   // response per accepted request and checks responses in order.
   // -----------------------------------------------------------------------------------------
   class bitmap_scoreboard;
      logic [WORD_BITS-1:0] words [DEPTH];
      logic [SIZE_W-1:0]    size_bits;
      result_type           expected_q[$];
      int                   errors;

      function new();
         foreach (words[i]) words[i] = '0;
         size_bits = SIZE_RESET;
         errors    = 0;
      endfunction

      function void set_size(input logic [SIZE_W-1:0] value);
         size_bits = value;
      endfunction

      // size with saturation at the store capacity
      function int active_bits();
         return (int'(size_bits) > MAX_BITS) ? MAX_BITS : int'(size_bits);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] idx);
         result_type res;
         int         nbits;
         int         nwords;
         int         w;
         nbits  = active_bits();
         nwords = (nbits + WORD_BITS - 1) / WORD_BITS;
         res    = '0;
         w      = int'(idx) / WORD_BITS;
         case (fn)
            FN_SET, FN_CLEAR, FN_READ: begin
               if (int'(idx) >= nbits) begin
                  res.error = 1'b1;
               end else if (fn == FN_SET) begin
                  words[w][idx % WORD_BITS] = 1'b1;
               end else if (fn == FN_CLEAR) begin
                  words[w][idx % WORD_BITS] = 1'b0;
               end else begin
                  res.bit_value = words[w][idx % WORD_BITS];
               end
            end
            FN_FIND: begin
               for (int i = 0; i < nwords && !res.found; i++) begin
                  for (int j = 0; j < WORD_BITS && !res.found; j++) begin
                     if (words[i][j]) begin
                        res.found       = 1'b1;
                        res.first_index = IDX_W'(i * WORD_BITS + j);
                     end
                  end
               end
            end
            // set all fills whole words, bits above the size in the last word included
            FN_SET_ALL:   for (int i = 0; i < nwords; i++) words[i] = '1;
            FN_CLEAR_ALL: for (int i = 0; i < nwords; i++) words[i] = '0;
            FN_TEST_EMPTY: begin
               res.is_empty = 1'b1;
               for (int i = 0; i < nwords; i++) if (words[i] != '0) res.is_empty = 1'b0;
            end
            default: ;
         endcase
         expected_q.push_back(res);
      endfunction

      task report_mismatch(input string what, input logic [IDX_W-1:0] got,
                           input logic [IDX_W-1:0] want);
         $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
         errors++;
      endtask

      task check_result(input logic [RSP_TDATA_W-1:0] tdata);
         result_type got;
         result_type want;
         got = tdata[RSP_W-1:0];
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected response beat", IDX_W'(tdata), '0);
         end else begin
            want = expected_q.pop_front();
            if (got.bit_value !== want.bit_value)
               report_mismatch("bit_value", got.bit_value, want.bit_value);
            if (got.found !== want.found)
               report_mismatch("found", got.found, want.found);
            if (got.first_index !== want.first_index)
               report_mismatch("first_index", got.first_index, want.first_index);
            if (got.is_empty !== want.is_empty)
               report_mismatch("is_empty", got.is_empty, want.is_empty);
            if (got.error !== want.error)
               report_mismatch("error", got.error, want.error);
            if (tdata[RSP_TDATA_W-1:RSP_W] !== '0)
               report_mismatch("pad bits", IDX_W'(tdata[RSP_TDATA_W-1:RSP_W]), '0);
         end
      endtask

      task check_leftover();
         if (expected_q.size() != 0)
            report_mismatch("responses never returned", IDX_W'(expected_q.size()), '0);
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [FUNC_W-1:0]      req_tuser;      // func[2:0]
   logic [REQ_TDATA_W-1:0] req_tdata;      // bit_index[9:0], zero pad [15:10]
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;      // bit_value, found, first_index[9:0], is_empty,
                                           // error, zero pad
   logic                   csr_wr_en;
   logic [SIZE_W-1:0]      csr_wr_data;

   bitmap_scoreboard sb;
   int send_idle_pct;
   int recv_stall_pct;
   int quiet_cycles;

   // idling per phase: none, sender only, receiver only, both
   int send_pattern [4] = '{0, 62, 0, 32};
   int recv_pattern [4] = '{0, 0, 62, 32};
   // size per random phase; the last one is drawn at random
   logic [SIZE_W-1:0] phase_sizes [NUM_PHASES] =
      '{11'd1024, 11'd1, 11'd33, 11'd2047, 11'd0, 11'd97, 11'd1024, 11'd32, 11'd1023, 11'd0};

   bitmap_store_with_find_first_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver: decide readiness at the falling edge so it is stable at the next rising edge.
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= recv_stall_pct);
   end

   // Response monitor: every accepted response beat goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // Watchdog: end the run if no beat moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no beat accepted for %0d cycles", $realtime, QUIET_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   // Send one request beat. Called at a falling edge; returns at the falling edge after the
   // beat is taken. Valid stays high into the next call unless that call idles first.
   task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = fn;
      req_tdata  = REQ_TDATA_W'(idx);
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      sb.note_request(fn, idx);
      @(negedge clock);
   endtask

   // Drop valid and hold until every expected response has come back.
   task automatic drain();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // Write the size register while the block is idle.
   task automatic write_size(input logic [SIZE_W-1:0] value);
      drain();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      sb.set_size(value);
   endtask

   // One random request. Most beats address bits in use so the store fills and empties in
   // interesting ways; a few hit the size boundary or any index at all.
   task automatic send_random_op();
      int                nbits;
      int                pick;
      int                spot;
      logic [FUNC_W-1:0] fn;
      logic [IDX_W-1:0]  idx;
      nbits = sb.active_bits();
      pick  = $urandom_range(99);
      if (pick < 30)      fn = FN_SET;
      else if (pick < 48) fn = FN_CLEAR;
      else if (pick < 66) fn = FN_READ;
      else if (pick < 80) fn = FN_FIND;
      else if (pick < 90) fn = FN_TEST_EMPTY;
      else if (pick < 93) fn = FN_SET_ALL;
      else if (pick < 97) fn = FN_CLEAR_ALL;
      else                fn = FN_UNUSED;
      spot = $urandom_range(9);
      if (nbits == 0 || spot == 0)
         idx = IDX_W'($urandom_range(1023));
      else if (spot == 1)
         idx = IDX_W'((nbits >= MAX_BITS) ? MAX_BITS - 1 : nbits - 1 + $urandom_range(1));
      else
         idx = IDX_W'($urandom_range(nbits - 1));
      send_op(fn, idx);
   endtask

   initial begin
      logic [SIZE_W-1:0] sz;
      sb             = new();
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tuser      = '0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      quiet_cycles   = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed: full size after reset --------------------------------------------------
      send_op(FN_TEST_EMPTY, 10'd0);     // cleared at reset
      send_op(FN_FIND, 10'd0);           // nothing to find
      send_op(FN_SET, 10'd1023);         // top bit
      send_op(FN_FIND, 10'd0);
      send_op(FN_READ, 10'd1023);
      send_op(FN_SET, 10'd0);            // bottom bit
      send_op(FN_FIND, 10'd0);
      send_op(FN_READ, 10'd512);
      send_op(FN_CLEAR, 10'd0);
      send_op(FN_CLEAR, 10'd1023);
      send_op(FN_TEST_EMPTY, 10'd0);
      send_op(FN_UNUSED, 10'd1023);      // no operation: all-zero response
      send_op(FN_SET_ALL, 10'd0);
      send_op(FN_TEST_EMPTY, 10'd0);
      send_op(FN_CLEAR_ALL, 10'd0);

      // one-bit size: set all fills the whole first word, so find reports bit 1 past the size
      write_size(11'd1);
      send_op(FN_SET_ALL, 10'd0);
      send_op(FN_CLEAR, 10'd0);
      send_op(FN_FIND, 10'd0);
      send_op(FN_READ, 10'd1);           // out of range

      // zero size: no words in use
      write_size(11'd0);
      send_op(FN_TEST_EMPTY, 10'd0);
      send_op(FN_FIND, 10'd0);
      send_op(FN_SET, 10'd0);

      // oversize saturates; words left from the small size are seen again
      write_size(11'd2047);
      send_op(FN_READ, 10'd1023);
      send_op(FN_FIND, 10'd0);
      send_op(FN_CLEAR_ALL, 10'd0);

      // ---- random phases: each drains, sets a size and an idling mix --------------------------
      for (int p = 0; p < NUM_PHASES; p++) begin
         sz = (p == NUM_PHASES - 1) ? SIZE_W'($urandom_range(2047)) : phase_sizes[p];
         write_size(sz);
         send_idle_pct  = send_pattern[p % 4];
         recv_stall_pct = recv_pattern[p % 4];
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_op();
      end

      // ---- wind down: wait for all responses, then a little longer for strays -----------------
      drain();
      recv_stall_pct = 0;
      repeat (TAIL_CYCLES) @(negedge clock);
      sb.check_leftover();
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
